### rtl/cpeb_pkg.sv
// Package for the circle pair elastic bounce unit.
// Holds the multiplier digit width, the radius reset value and the flag bundle.
// No dependencies.
package cpeb_pkg;

    localparam int MUL_CHUNK = 16;
    localparam int unsigned RADIUS_RESET = 655360;

    typedef struct packed {
        logic overlap;
        logic bounce;
        logic impulse;
        logic neg_ax;
        logic neg_ay;
        logic neg_bx;
        logic neg_by;
    } flags_t;

endpackage

### rtl/circle_pair_elastic_bounce_unit.sv
// Circle pair elastic bounce unit: top level.
// Depends on cpeb_pkg, cpeb_mul and cpeb_div.
//
// One request carries two bodies (positions, velocities, masses); one result
// carries both new velocities and the overlap and bounce flags. The unit takes
// a request every cycle while in_ready is high and returns results in order.
// Most of the pipeline is the restoring divider, which resolves one quotient
// bit per stage. A two-entry output buffer lets a new request in while a
// finished result waits; in_ready drops once it is full.
module circle_pair_elastic_bounce_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [WORD_BITS-2:0]        cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [WORD_BITS-1:0] a_pos_x,
    input  logic signed [WORD_BITS-1:0] a_pos_y,
    input  logic signed [WORD_BITS-1:0] b_pos_x,
    input  logic signed [WORD_BITS-1:0] b_pos_y,
    input  logic signed [WORD_BITS-1:0] a_vel_x,
    input  logic signed [WORD_BITS-1:0] a_vel_y,
    input  logic signed [WORD_BITS-1:0] b_vel_x,
    input  logic signed [WORD_BITS-1:0] b_vel_y,
    input  logic [WORD_BITS-2:0]        a_mass,
    input  logic [WORD_BITS-2:0]        b_mass,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [WORD_BITS-1:0] a_new_vel_x,
    output logic signed [WORD_BITS-1:0] a_new_vel_y,
    output logic signed [WORD_BITS-1:0] b_new_vel_x,
    output logic signed [WORD_BITS-1:0] b_new_vel_y,
    output logic                        overlapping,
    output logic                        bounced
);

    localparam int W    = WORD_BITS;
    localparam int CH   = cpeb_pkg::MUL_CHUNK;
    localparam int SQW  = 2 * W;
    localparam int D2W  = SQW + 1;
    localparam int MDW  = 2 * W - 1;
    localparam int PRW  = MDW + D2W;
    localparam int NUMW = 4 * W + 2;
    localparam int DENW = 3 * W + 2;
    localparam int Q    = W + 2;
    localparam int SUMW = W + 4;
    localparam int L1   = (W + CH - 1) / CH;
    localparam int L2   = (W - 1 + CH - 1) / CH;
    localparam int L3   = (D2W + CH - 1) / CH;
    localparam int NST  = 6 + L1 + L2 + L3 + Q;

    typedef struct packed {
        logic sdx, sdy, srx, sry, dxpos, dypos;
        logic [W-1:0] avx, avy, bvx, bvy;
        logic [W-2:0] ma, mb;
        logic [W-1:0] msum;
        logic [W-1:0] mdx, mdy;
    } m1_side_t;

    typedef struct packed {
        cpeb_pkg::flags_t flags;
        logic [D2W-1:0]   pm;
        logic [D2W-1:0]   d2;
        logic [W-1:0]     msum;
        logic [W-1:0]     avx, avy, bvx, bvy;
    } m2_side_t;

    typedef struct packed {
        cpeb_pkg::flags_t flags;
        logic [W-1:0]     avx, avy, bvx, bvy;
    } m3_side_t;

    typedef struct packed {
        logic [W-1:0] vax, vay, vbx, vby;
        logic         overlap;
        logic         bounce;
    } out_t;

    function automatic logic [W-1:0] sat_add(input logic [W-1:0] v, input logic [Q-1:0] q,
                                             input logic neg, input logic apply);
        logic [SUMW-1:0] ve;
        logic [SUMW-1:0] qe;
        logic [SUMW-1:0] s;
        logic [W-1:0]    r;
        ve = SUMW'($signed(v));
        qe = apply ? SUMW'(q) : '0;
        s  = neg ? (ve - qe) : (ve + qe);
        if ((&s[SUMW-1:W-1]) || !(|s[SUMW-1:W-1]))
            r = s[W-1:0];
        else if (s[SUMW-1])
            r = {1'b1, {(W-1){1'b0}}};
        else
            r = {1'b0, {(W-1){1'b1}}};
        return r;
    endfunction

    logic           en;
    logic [NST-1:0] vld_reg;
    logic [W-2:0]   radius_reg;

    // stage 1
    logic [W:0]   dx_reg, dy_reg, rx_reg, ry_reg;
    logic [W-1:0] avx_reg, avy_reg, bvx_reg, bvy_reg;
    logic [W-2:0] ma_reg, mb_reg;
    logic [W-1:0] msum_reg;
    // stage 2
    logic [W-1:0] mdx_reg, mdy_reg, mrx_reg, mry_reg;
    m1_side_t     s2_side_reg;
    // stage 3
    logic [D2W-1:0] d2_reg, pm_reg;
    logic [SQW-1:0] rs2_reg;
    logic           pneg_reg;
    m1_side_t       s3_side_reg;
    // stage 4
    logic [D2W-1:0]   d2b_reg, pmb_reg;
    cpeb_pkg::flags_t flags_reg;
    m1_side_t         s4_side_reg;
    // stage 5
    logic [NUMW-1:0] num_ax_reg, num_ay_reg, num_bx_reg, num_by_reg;
    logic [DENW-1:0] den2_reg;
    m3_side_t        s5_side_reg;
    // stage 6 and output buffer
    out_t s6_reg;
    out_t main_reg, skid_reg;
    logic main_vld_reg, skid_vld_reg;

    assign en       = !skid_vld_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= (W-1)'(cpeb_pkg::RADIUS_RESET);
        else if (cfg_wr_en)
            radius_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end

    // stage 1 and 2: differences, then magnitudes and signs
    logic [W:0] dx_neg, dy_neg, rx_neg, ry_neg;
    assign dx_neg = -dx_reg;
    assign dy_neg = -dy_reg;
    assign rx_neg = -rx_reg;
    assign ry_neg = -ry_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= {b_pos_x[W-1], b_pos_x} - {a_pos_x[W-1], a_pos_x};
            dy_reg   <= {b_pos_y[W-1], b_pos_y} - {a_pos_y[W-1], a_pos_y};
            rx_reg   <= {b_vel_x[W-1], b_vel_x} - {a_vel_x[W-1], a_vel_x};
            ry_reg   <= {b_vel_y[W-1], b_vel_y} - {a_vel_y[W-1], a_vel_y};
            avx_reg  <= a_vel_x;
            avy_reg  <= a_vel_y;
            bvx_reg  <= b_vel_x;
            bvy_reg  <= b_vel_y;
            ma_reg   <= a_mass;
            mb_reg   <= b_mass;
            msum_reg <= {1'b0, a_mass} + {1'b0, b_mass};

            mdx_reg <= dx_reg[W] ? dx_neg[W-1:0] : dx_reg[W-1:0];
            mdy_reg <= dy_reg[W] ? dy_neg[W-1:0] : dy_reg[W-1:0];
            mrx_reg <= rx_reg[W] ? rx_neg[W-1:0] : rx_reg[W-1:0];
            mry_reg <= ry_reg[W] ? ry_neg[W-1:0] : ry_reg[W-1:0];
            s2_side_reg.sdx   <= dx_reg[W];
            s2_side_reg.sdy   <= dy_reg[W];
            s2_side_reg.srx   <= rx_reg[W];
            s2_side_reg.sry   <= ry_reg[W];
            s2_side_reg.dxpos <= !dx_reg[W] && (dx_reg != '0);
            s2_side_reg.dypos <= !dy_reg[W] && (dy_reg != '0);
            s2_side_reg.avx   <= avx_reg;
            s2_side_reg.avy   <= avy_reg;
            s2_side_reg.bvx   <= bvx_reg;
            s2_side_reg.bvy   <= bvy_reg;
            s2_side_reg.ma    <= ma_reg;
            s2_side_reg.mb    <= mb_reg;
            s2_side_reg.msum  <= msum_reg;
            s2_side_reg.mdx   <= dx_reg[W] ? dx_neg[W-1:0] : dx_reg[W-1:0];
            s2_side_reg.mdy   <= dy_reg[W] ? dy_neg[W-1:0] : dy_reg[W-1:0];
        end
    end

    // squares and normal products
    logic [SQW-1:0] dx2, dy2, rs2, t1, t2;
    m1_side_t       m1_side;

    cpeb_mul #(.AW(W), .BW(W), .SW($bits(m1_side_t))) u_sq_dx (
        .clk(clk), .en(en), .a(mdx_reg), .b(mdx_reg),
        .side_in(s2_side_reg), .p(dx2), .side_out(m1_side)
    );
    cpeb_mul #(.AW(W), .BW(W), .SW(1)) u_sq_dy (
        .clk(clk), .en(en), .a(mdy_reg), .b(mdy_reg),
        .side_in(1'b0), .p(dy2), .side_out()
    );
    cpeb_mul #(.AW(W), .BW(W), .SW(1)) u_sq_rs (
        .clk(clk), .en(en), .a({radius_reg, 1'b0}), .b({radius_reg, 1'b0}),
        .side_in(1'b0), .p(rs2), .side_out()
    );
    cpeb_mul #(.AW(W), .BW(W), .SW(1)) u_pr_x (
        .clk(clk), .en(en), .a(mrx_reg), .b(mdx_reg),
        .side_in(1'b0), .p(t1), .side_out()
    );
    cpeb_mul #(.AW(W), .BW(W), .SW(1)) u_pr_y (
        .clk(clk), .en(en), .a(mry_reg), .b(mdy_reg),
        .side_in(1'b0), .p(t2), .side_out()
    );

    // stage 3: squared distance and normal relative speed
    logic           p1neg, p2neg, t1ge;
    logic [D2W-1:0] psum, d12, d21, pm_next;
    logic           pneg_next;

    always_comb
    begin
        p1neg = m1_side.srx ^ m1_side.sdx;
        p2neg = m1_side.sry ^ m1_side.sdy;
        psum  = D2W'(t1) + D2W'(t2);
        d12   = {1'b0, t1} - {1'b0, t2};
        d21   = {1'b0, t2} - {1'b0, t1};
        t1ge  = !d12[D2W-1];
        if (p1neg == p2neg)
        begin
            pm_next   = psum;
            pneg_next = p1neg;
        end
        else if (t1ge)
        begin
            pm_next   = d12;
            pneg_next = p1neg;
        end
        else
        begin
            pm_next   = d21;
            pneg_next = p2neg;
        end
    end

    // stage 4: overlap and bounce decision
    logic pm_zero, pneg_eff, overlap_next, bounce_next;
    cpeb_pkg::flags_t flags_next;

    always_comb
    begin
        pm_zero      = (pm_reg == '0);
        pneg_eff     = pneg_reg && !pm_zero;
        overlap_next = d2_reg < D2W'(rs2_reg);
        bounce_next  = overlap_next && (d2_reg != '0) && (pneg_eff || pm_zero)
                       && (s3_side_reg.msum != '0);
        flags_next.overlap = overlap_next;
        flags_next.bounce  = bounce_next;
        flags_next.impulse = bounce_next && pneg_eff;
        flags_next.neg_ax  = s3_side_reg.dxpos;
        flags_next.neg_ay  = s3_side_reg.dypos;
        flags_next.neg_bx  = s3_side_reg.sdx;
        flags_next.neg_by  = s3_side_reg.sdy;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_reg      <= D2W'(dx2) + D2W'(dy2);
            rs2_reg     <= rs2;
            pm_reg      <= pm_next;
            pneg_reg    <= pneg_next;
            s3_side_reg <= m1_side;

            d2b_reg     <= d2_reg;
            pmb_reg     <= pm_reg;
            flags_reg   <= flags_next;
            s4_side_reg <= s3_side_reg;
        end
    end

    // mass times distance component
    m2_side_t       m2_side_in, m2_side;
    logic [MDW-1:0] md_ax, md_ay, md_bx, md_by;

    always_comb
    begin
        m2_side_in.flags = flags_reg;
        m2_side_in.pm    = pmb_reg;
        m2_side_in.d2    = d2b_reg;
        m2_side_in.msum  = s4_side_reg.msum;
        m2_side_in.avx   = s4_side_reg.avx;
        m2_side_in.avy   = s4_side_reg.avy;
        m2_side_in.bvx   = s4_side_reg.bvx;
        m2_side_in.bvy   = s4_side_reg.bvy;
    end

    cpeb_mul #(.AW(W), .BW(W-1), .SW($bits(m2_side_t))) u_md_ax (
        .clk(clk), .en(en), .a(s4_side_reg.mdx), .b(s4_side_reg.mb),
        .side_in(m2_side_in), .p(md_ax), .side_out(m2_side)
    );
    cpeb_mul #(.AW(W), .BW(W-1), .SW(1)) u_md_ay (
        .clk(clk), .en(en), .a(s4_side_reg.mdy), .b(s4_side_reg.mb),
        .side_in(1'b0), .p(md_ay), .side_out()
    );
    cpeb_mul #(.AW(W), .BW(W-1), .SW(1)) u_md_bx (
        .clk(clk), .en(en), .a(s4_side_reg.mdx), .b(s4_side_reg.ma),
        .side_in(1'b0), .p(md_bx), .side_out()
    );
    cpeb_mul #(.AW(W), .BW(W-1), .SW(1)) u_md_by (
        .clk(clk), .en(en), .a(s4_side_reg.mdy), .b(s4_side_reg.ma),
        .side_in(1'b0), .p(md_by), .side_out()
    );

    // numerator products and denominator
    m3_side_t         m3_side_in, m3_side;
    logic [PRW-1:0]   pr_ax, pr_ay, pr_bx, pr_by;
    logic [2*D2W-1:0] den_full;

    always_comb
    begin
        m3_side_in.flags = m2_side.flags;
        m3_side_in.avx   = m2_side.avx;
        m3_side_in.avy   = m2_side.avy;
        m3_side_in.bvx   = m2_side.bvx;
        m3_side_in.bvy   = m2_side.bvy;
    end

    cpeb_mul #(.AW(MDW), .BW(D2W), .SW(1)) u_nm_ax (
        .clk(clk), .en(en), .a(md_ax), .b(m2_side.pm),
        .side_in(1'b0), .p(pr_ax), .side_out()
    );
    cpeb_mul #(.AW(MDW), .BW(D2W), .SW(1)) u_nm_ay (
        .clk(clk), .en(en), .a(md_ay), .b(m2_side.pm),
        .side_in(1'b0), .p(pr_ay), .side_out()
    );
    cpeb_mul #(.AW(MDW), .BW(D2W), .SW(1)) u_nm_bx (
        .clk(clk), .en(en), .a(md_bx), .b(m2_side.pm),
        .side_in(1'b0), .p(pr_bx), .side_out()
    );
    cpeb_mul #(.AW(MDW), .BW(D2W), .SW(1)) u_nm_by (
        .clk(clk), .en(en), .a(md_by), .b(m2_side.pm),
        .side_in(1'b0), .p(pr_by), .side_out()
    );
    cpeb_mul #(.AW(D2W), .BW(D2W), .SW($bits(m3_side_t))) u_den (
        .clk(clk), .en(en), .a(m2_side.d2), .b(D2W'(m2_side.msum)),
        .side_in(m3_side_in), .p(den_full), .side_out(m3_side)
    );

    // stage 5: rounded numerators and doubled denominator
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_ax_reg  <= NUMW'({pr_ax, 2'b00}) + NUMW'(den_full[DENW-2:0]);
            num_ay_reg  <= NUMW'({pr_ay, 2'b00}) + NUMW'(den_full[DENW-2:0]);
            num_bx_reg  <= NUMW'({pr_bx, 2'b00}) + NUMW'(den_full[DENW-2:0]);
            num_by_reg  <= NUMW'({pr_by, 2'b00}) + NUMW'(den_full[DENW-2:0]);
            den2_reg    <= {den_full[DENW-2:0], 1'b0};
            s5_side_reg <= m3_side;
        end
    end

    // velocity change magnitudes
    logic [Q-1:0] q_ax, q_ay, q_bx, q_by;
    m3_side_t     dv_side;

    cpeb_div #(.NW(NUMW), .DW(DENW), .QW(Q), .SW($bits(m3_side_t))) u_dv_ax (
        .clk(clk), .en(en), .num(num_ax_reg), .den(den2_reg),
        .side_in(s5_side_reg), .quo(q_ax), .side_out(dv_side)
    );
    cpeb_div #(.NW(NUMW), .DW(DENW), .QW(Q), .SW(1)) u_dv_ay (
        .clk(clk), .en(en), .num(num_ay_reg), .den(den2_reg),
        .side_in(1'b0), .quo(q_ay), .side_out()
    );
    cpeb_div #(.NW(NUMW), .DW(DENW), .QW(Q), .SW(1)) u_dv_bx (
        .clk(clk), .en(en), .num(num_bx_reg), .den(den2_reg),
        .side_in(1'b0), .quo(q_bx), .side_out()
    );
    cpeb_div #(.NW(NUMW), .DW(DENW), .QW(Q), .SW(1)) u_dv_by (
        .clk(clk), .en(en), .num(num_by_reg), .den(den2_reg),
        .side_in(1'b0), .quo(q_by), .side_out()
    );

    // stage 6: apply and saturate
    out_t s6_next;

    always_comb
    begin
        s6_next.vax = sat_add(dv_side.avx, q_ax, dv_side.flags.neg_ax, dv_side.flags.impulse);
        s6_next.vay = sat_add(dv_side.avy, q_ay, dv_side.flags.neg_ay, dv_side.flags.impulse);
        s6_next.vbx = sat_add(dv_side.bvx, q_bx, dv_side.flags.neg_bx, dv_side.flags.impulse);
        s6_next.vby = sat_add(dv_side.bvy, q_by, dv_side.flags.neg_by, dv_side.flags.impulse);
        s6_next.overlap = dv_side.flags.overlap;
        s6_next.bounce  = dv_side.flags.bounce;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s6_reg <= s6_next;
    end

    // output buffer: hold the result, park one more in the skid entry
    logic take_main;
    assign take_main = !main_vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (take_main)
        begin
            if (skid_vld_reg)
            begin
                main_vld_reg <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                main_vld_reg <= vld_reg[NST-1];
            end
        end
        else if (en && vld_reg[NST-1])
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_main)
        begin
            if (skid_vld_reg)
                main_reg <= skid_reg;
            else
                main_reg <= s6_reg;
        end
        else if (en)
        begin
            skid_reg <= s6_reg;
        end
    end

    assign out_valid   = main_vld_reg;
    assign a_new_vel_x = main_reg.vax;
    assign a_new_vel_y = main_reg.vay;
    assign b_new_vel_x = main_reg.vbx;
    assign b_new_vel_y = main_reg.vby;
    assign overlapping = main_reg.overlap;
    assign bounced     = main_reg.bounce;

endmodule

### rtl/cpeb_mul.sv
// Pipelined unsigned multiplier, one MUL_CHUNK-bit digit of b per stage.
// Carries a side payload alongside the product; all stages advance on en.
// Depends on cpeb_pkg.
module cpeb_mul #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SW = 1
) (
    input  logic              clk,
    input  logic              en,
    input  logic [AW-1:0]     a,
    input  logic [BW-1:0]     b,
    input  logic [SW-1:0]     side_in,
    output logic [AW+BW-1:0]  p,
    output logic [SW-1:0]     side_out
);

    localparam int CH  = cpeb_pkg::MUL_CHUNK;
    localparam int NS  = (BW + CH - 1) / CH;
    localparam int PW  = AW + BW;
    localparam int BPW = NS * CH;

    logic [AW-1:0]  a_reg    [NS];
    logic [BPW-1:0] b_reg    [NS];
    logic [PW-1:0]  acc_reg  [NS];
    logic [SW-1:0]  side_reg [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic [AW-1:0]    a_next;
        logic [BPW-1:0]   b_next;
        logic [PW-1:0]    acc_in;
        logic [PW-1:0]    acc_next;
        logic [SW-1:0]    side_next;
        logic [AW+CH-1:0] part;

        if (k == 0)
        begin : g_first
            assign a_next    = a;
            assign b_next    = BPW'(b);
            assign acc_in    = '0;
            assign side_next = side_in;
        end
        else
        begin : g_rest
            assign a_next    = a_reg[k-1];
            assign b_next    = b_reg[k-1];
            assign acc_in    = acc_reg[k-1];
            assign side_next = side_reg[k-1];
        end

        assign part     = (AW+CH)'(a_next) * (AW+CH)'(b_next[k*CH +: CH]);
        assign acc_next = acc_in + (PW'(part) << (k * CH));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_reg[k]    <= a_next;
                b_reg[k]    <= b_next;
                acc_reg[k]  <= acc_next;
                side_reg[k] <= side_next;
            end
        end
    end

    assign p        = acc_reg[NS-1];
    assign side_out = side_reg[NS-1];

endmodule

### rtl/cpeb_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit QW bits; carries a side payload; all stages advance on en.
// No package dependencies.
module cpeb_div #(
    parameter int NW = 130,
    parameter int DW = 98,
    parameter int QW = 34,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] sh_reg   [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] sh_in;
        logic [DW-1:0] den_next;
        logic [SW-1:0] side_next;
        logic [DW:0]   trial;
        logic [DW+1:0] diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] sh_next;

        if (k == 0)
        begin : g_first
            assign rem_in    = DW'(num[NW-1:QW]);
            assign sh_in     = num[QW-1:0];
            assign den_next  = den;
            assign side_next = side_in;
        end
        else
        begin : g_rest
            assign rem_in    = rem_reg[k-1];
            assign sh_in     = sh_reg[k-1];
            assign den_next  = den_reg[k-1];
            assign side_next = side_reg[k-1];
        end

        assign trial    = {rem_in, sh_in[QW-1]};
        assign diff     = {1'b0, trial} - {2'b00, den_next};
        assign ge       = !diff[DW+1];
        assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        assign sh_next  = {sh_in[QW-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                sh_reg[k]   <= sh_next;
                den_reg[k]  <= den_next;
                side_reg[k] <= side_next;
            end
        end
    end

    assign quo      = sh_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule
